/* src/lru_symbol_to_code_map_core_assert.svh */
// Assertion macros shared by the map core RTL.
// LSTCM_ASSERT checks after reset; LSTCM_ASSERT_RST checks on every edge.
`ifndef LRU_SYMBOL_TO_CODE_MAP_CORE_ASSERT_SVH
`define LRU_SYMBOL_TO_CODE_MAP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LSTCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define LSTCM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSTCM_ASSERT(lbl, prop, msg)
`define LSTCM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* src/lstcm_pkg.sv */
package lstcm_pkg;

    // Operation codes of a request
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // A slot at or above this stamp is never evicted
    localparam logic [31:0] TIME_LIMIT = 32'hFFFF_FFFE;

    // Entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        operation;
        logic [31:0] key_symbol;
        logic [31:0] now_ms;
        logic [7:0]  slot_index;
        logic        slot_pinned;
    } req_item_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       hit;
        logic       remapped;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CMD_LOOKUP,
        CMD_LOAD,
        CMD_LOAD_SKIP,
        CMD_NO_RANGE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] symbol;
        logic [31:0] stamp;
        logic [7:0]  index;
        logic        pin;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic [31:0] symbol;
        logic [31:0] stamp;
        logic        pin;
    } slot_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

endpackage

/* src/lstcm_front.sv */
module lstcm_front
    import lstcm_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MIN_CODE    = 8,
    parameter int MAX_CODE    = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_item_t  req_item,
    input  logic       init_done,
    input  fifo_stat_t q_stat,
    output logic       q_push,
    output cmd_t       q_cmd
);

    localparam int SCAN_END    = (MAX_CODE < TABLE_DEPTH) ? MAX_CODE : TABLE_DEPTH;
    localparam bit RANGE_EMPTY = (MIN_CODE >= SCAN_END);

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    // Classify the incoming request
    always_comb
    begin
        cmd_next.symbol = req_item.key_symbol;
        cmd_next.index  = req_item.slot_index;
        cmd_next.pin    = req_item.slot_pinned;
        cmd_next.stamp  = req_item.now_ms;
        cmd_next.kind   = CMD_LOOKUP;
        unique case (req_item.operation)
            OP_LOAD:
            begin
                cmd_next.kind = (int'(req_item.slot_index) < TABLE_DEPTH) ?
                                CMD_LOAD : CMD_LOAD_SKIP;
                if (req_item.key_symbol == 32'd0)
                begin
                    cmd_next.stamp = 32'd0;
                end
            end
            OP_LOOKUP:
            begin
                cmd_next.kind = RANGE_EMPTY ? CMD_NO_RANGE : CMD_LOOKUP;
            end
            default:
            begin
                cmd_next.kind = CMD_LOOKUP;
            end
        endcase
    end

    // Hold one classified command until the queue takes it
    assign q_push    = cmd_valid_reg && !q_stat.full;
    assign req_ready = init_done && (!cmd_valid_reg || !q_stat.full);
    assign accept    = req_valid && req_ready;
    assign q_cmd     = cmd_reg;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* src/lstcm_fifo.sv */
`include "lru_symbol_to_code_map_core_assert.svh"

module lstcm_fifo
    import lstcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output cmd_t       pop_cmd,
    output fifo_stat_t stat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    cmd_t          slots_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `LSTCM_ASSERT(a_no_push_full, push |-> !stat.full, "queue push while full")
    `LSTCM_ASSERT(a_no_pop_empty, pop |-> !stat.empty, "queue pop while empty")
    `LSTCM_ASSERT_RST(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "queue count overflow")

endmodule

/* src/lstcm_back.sv */
`include "lru_symbol_to_code_map_core_assert.svh"

module lstcm_back
    import lstcm_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MIN_CODE    = 8,
    parameter int MAX_CODE    = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  fifo_stat_t q_stat,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       init_done,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_item_t  rsp_item
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int SCAN_END = (MAX_CODE < TABLE_DEPTH) ? MAX_CODE : TABLE_DEPTH;
    localparam logic [AW-1:0] FIRST_ADDR = AW'(MIN_CODE);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(SCAN_END - 1);
    localparam logic [AW-1:0] CLEAR_LAST = AW'(TABLE_DEPTH - 1);

    // Slot store
    slot_t         slot_mem [TABLE_DEPTH];
    slot_t         rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_t         wr_data;

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic [AW-1:0] chk_addr_reg;
    logic [AW-1:0] chk_addr_next;
    cmd_t          cmd_reg;
    cmd_t          cmd_next;
    logic [AW-1:0] best_addr_reg;
    logic [AW-1:0] best_addr_next;
    logic [31:0]   best_time_reg;
    logic [31:0]   best_time_next;
    logic          found_reg;
    logic          found_next;
    logic          fin_wr_reg;
    logic          fin_wr_next;
    logic [AW-1:0] fin_addr_reg;
    logic [AW-1:0] fin_addr_next;
    slot_t         fin_data_reg;
    slot_t         fin_data_next;
    rsp_item_t     fin_rsp_reg;
    rsp_item_t     fin_rsp_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    rsp_item_t     out_item_reg;
    rsp_item_t     out_item_next;
    logic          out_load;
    logic          out_free;

    // Scan compare on the entry read last cycle
    logic          scan_match;
    logic          scan_elig;
    logic          scan_last;
    logic          scan_found;
    logic          cand_found;
    logic [AW-1:0] cand_addr;
    logic [31:0]   cand_time;
    logic [31:0]   hit_time;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_stat.empty && out_free;
    assign init_done = (state_reg != ST_CLEAR);
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

    assign scan_match = (rd_data_reg.symbol == cmd_reg.symbol);
    assign scan_elig  = !rd_data_reg.pin && (rd_data_reg.stamp < best_time_reg);
    assign scan_last  = (chk_addr_reg == LAST_ADDR);
    assign scan_found = (state_reg == ST_SCAN) && found_reg;
    assign cand_found = found_reg || scan_elig;
    assign cand_addr  = scan_elig ? chk_addr_reg : best_addr_reg;
    assign cand_time  = scan_elig ? rd_data_reg.stamp : best_time_reg;
    assign hit_time   = (cmd_reg.stamp > rd_data_reg.stamp) ? cmd_reg.stamp
                                                            : rd_data_reg.stamp;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_pop && (q_cmd.kind == CMD_LOOKUP))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_match || scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath, memory port and result control
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        chk_addr_next  = chk_addr_reg;
        cmd_next       = cmd_reg;
        best_addr_next = best_addr_reg;
        best_time_next = best_time_reg;
        found_next     = found_reg;
        fin_wr_next    = fin_wr_reg;
        fin_addr_next  = fin_addr_reg;
        fin_data_next  = fin_data_reg;
        fin_rsp_next   = fin_rsp_reg;
        rd_addr        = FIRST_ADDR;
        wr_en          = 1'b0;
        wr_addr        = clr_addr_reg;
        wr_data        = '0;
        out_load       = 1'b0;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_cmd.kind)
                        CMD_LOOKUP:
                        begin
                            cmd_next       = q_cmd;
                            chk_addr_next  = FIRST_ADDR;
                            best_time_next = TIME_LIMIT;
                            best_addr_next = '0;
                            found_next     = 1'b0;
                        end
                        CMD_LOAD:
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = AW'(q_cmd.index);
                            wr_data.symbol = q_cmd.symbol;
                            wr_data.stamp  = q_cmd.stamp;
                            wr_data.pin    = q_cmd.pin;
                            out_load       = 1'b1;
                            out_item_next  = '{key_code: q_cmd.index, hit: 1'b0,
                                               remapped: 1'b0};
                        end
                        CMD_LOAD_SKIP:
                        begin
                            out_load      = 1'b1;
                            out_item_next = '{key_code: q_cmd.index, hit: 1'b0,
                                              remapped: 1'b0};
                        end
                        CMD_NO_RANGE:
                        begin
                            out_load      = 1'b1;
                            out_item_next = '0;
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Read one slot ahead; stay on the last slot at the range end
                rd_addr        = scan_last ? chk_addr_reg : chk_addr_reg + 1'b1;
                chk_addr_next  = chk_addr_reg + 1'b1;
                best_addr_next = cand_addr;
                best_time_next = cand_time;
                found_next     = cand_found;
                if (scan_match)
                begin
                    fin_wr_next          = 1'b1;
                    fin_addr_next        = chk_addr_reg;
                    fin_data_next.symbol = rd_data_reg.symbol;
                    fin_data_next.stamp  = hit_time;
                    fin_data_next.pin    = rd_data_reg.pin;
                    fin_rsp_next         = '{key_code: 8'(chk_addr_reg), hit: 1'b1,
                                             remapped: 1'b0};
                end
                else if (cand_found)
                begin
                    fin_wr_next          = 1'b1;
                    fin_addr_next        = cand_addr;
                    fin_data_next.symbol = cmd_reg.symbol;
                    fin_data_next.stamp  = cmd_reg.stamp;
                    fin_data_next.pin    = 1'b0;
                    fin_rsp_next         = '{key_code: 8'(cand_addr), hit: 1'b0,
                                             remapped: 1'b1};
                end
                else
                begin
                    fin_wr_next   = 1'b0;
                    fin_addr_next = chk_addr_reg;
                    fin_data_next = '0;
                    fin_rsp_next  = '0;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    wr_en         = fin_wr_reg;
                    wr_addr       = fin_addr_reg;
                    wr_data       = fin_data_reg;
                    out_load      = 1'b1;
                    out_item_next = fin_rsp_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Hold the result until the consumer takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg  <= chk_addr_next;
        cmd_reg       <= cmd_next;
        best_addr_reg <= best_addr_next;
        best_time_reg <= best_time_next;
        found_reg     <= found_next;
        fin_wr_reg    <= fin_wr_next;
        fin_addr_reg  <= fin_addr_next;
        fin_data_reg  <= fin_data_next;
        fin_rsp_reg   <= fin_rsp_next;
        out_item_reg  <= out_item_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    `LSTCM_ASSERT(a_pop_in_idle, q_pop |-> (state_reg == ST_IDLE), "pop outside idle")
    `LSTCM_ASSERT(a_no_write_scan, wr_en |-> (state_reg != ST_SCAN), "slot write during scan")
    `LSTCM_ASSERT(a_out_free, out_load |-> (!out_valid_reg || rsp_ready), "result overwritten")
    `LSTCM_ASSERT(a_best_bound, scan_found |-> (best_time_reg < TIME_LIMIT), "victim not eligible")

endmodule

/* src/lru_symbol_to_code_map_core.sv */
// Fully associative symbol-to-code map with least-recently-used rebinding.
// After reset the slot memory is swept to zero, one slot per cycle, and
// req_ready stays low until the sweep ends. A load is written to the slot
// memory from the idle state, with no scan. A lookup reads the slot memory one
// slot per cycle over codes MIN_CODE up to min(MAX_CODE, TABLE_DEPTH) - 1 and
// stops at the first matching slot or at the end of that range; the single
// read port of the slot memory sets this rate. Requests queue in front of the
// back end (two commands plus one holding register), and a finished result
// sits in an output register until the consumer takes it; the back end takes
// no new command while that register is full and not being read.
module lru_symbol_to_code_map_core
    import lstcm_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MIN_CODE    = 8,
    parameter int MAX_CODE    = 255
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_item
);

    fifo_stat_t q_stat;
    logic       q_push;
    cmd_t       q_push_cmd;
    logic       q_pop;
    cmd_t       q_pop_cmd;
    logic       init_done;

    lstcm_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MIN_CODE    (MIN_CODE),
        .MAX_CODE    (MAX_CODE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .init_done (init_done),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    lstcm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .stat     (q_stat)
    );

    lstcm_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MIN_CODE    (MIN_CODE),
        .MAX_CODE    (MAX_CODE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_cmd     (q_pop_cmd),
        .q_pop     (q_pop),
        .init_done (init_done),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

/* dv/lru_symbol_to_code_map_core_test.sv */
module lru_symbol_to_code_map_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lstcm_pkg::*;

    localparam int MAP_DEPTH    = 256;
    localparam int FIRST_CODE   = 8;
    localparam int LAST_CODE    = 255;
    localparam int END_CODE     = (LAST_CODE > MAP_DEPTH) ? MAP_DEPTH : LAST_CODE;
    localparam int ITEM_TARGET  = 1850;
    localparam int TAIL_ITEMS   = 150;
    localparam int LONG_HOLD    = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 2500000;
    localparam int POOL_SIZE    = 320;

    // Shadow copy of the slot table and the queue of codes still owed by the block
    class code_map_scoreboard;
        logic [31:0] sym_tab [MAP_DEPTH];
        logic [31:0] stamp_tab [MAP_DEPTH];
        bit          pin_tab [MAP_DEPTH];
        rsp_item_t   expected_codes [$];
        int          errors;

        function new();
            for (int i = 0; i < MAP_DEPTH; i++)
            begin
                sym_tab[i]   = '0;
                stamp_tab[i] = '0;
                pin_tab[i]   = 1'b0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction

        // Apply one accepted transfer to the shadow table and queue its code
        function void note_request(req_item_t it);
            rsp_item_t   want;
            logic [31:0] best_stamp;
            int          best;
            bit          found;
            bit          done;
            want = '0;
            if (it.operation == OP_LOAD)
            begin
                if (int'(it.slot_index) < MAP_DEPTH)
                begin
                    sym_tab[it.slot_index]   = it.key_symbol;
                    stamp_tab[it.slot_index] = (it.key_symbol == 32'd0) ? 32'd0 : it.now_ms;
                    pin_tab[it.slot_index]   = it.slot_pinned;
                end
                want.key_code = it.slot_index;
            end
            else
            begin
                best_stamp = TIME_LIMIT;
                best       = 0;
                found      = 1'b0;
                done       = 1'b0;
                // lowest matching slot wins; track the oldest evictable slot on the way
                for (int i = FIRST_CODE; i < END_CODE && !done; i++)
                begin
                    if (sym_tab[i] == it.key_symbol)
                    begin
                        if (it.now_ms > stamp_tab[i])
                            stamp_tab[i] = it.now_ms;
                        want.key_code = 8'(i);
                        want.hit      = 1'b1;
                        done          = 1'b1;
                    end
                    else if (!pin_tab[i] && stamp_tab[i] < best_stamp)
                    begin
                        best_stamp = stamp_tab[i];
                        best       = i;
                        found      = 1'b1;
                    end
                end
                // rebind the least recently used slot on a miss
                if (!done && found)
                begin
                    sym_tab[best]   = it.key_symbol;
                    stamp_tab[best] = it.now_ms;
                    want.key_code   = 8'(best);
                    want.remapped   = 1'b1;
                end
            end
            expected_codes.push_back(want);
        endfunction

        // Compare one result transfer with the oldest code owed
        function void check_code(rsp_item_t got);
            rsp_item_t want;
            if (expected_codes.size() == 0)
            begin
                $display("%0t: result with none expected: key_code %0d hit %0b remapped %0b",
                         $time, got.key_code, got.hit, got.remapped);
                errors++;
                return;
            end
            want = expected_codes.pop_front();
            if (got.key_code !== want.key_code)
            begin
                $display("%0t: wrong key_code: expected %0d actual %0d",
                         $time, want.key_code, got.key_code);
                errors++;
            end
            if (got.hit !== want.hit)
            begin
                $display("%0t: wrong hit: expected %0b actual %0b", $time, want.hit, got.hit);
                errors++;
            end
            if (got.remapped !== want.remapped)
            begin
                $display("%0t: wrong remapped: expected %0b actual %0b",
                         $time, want.remapped, got.remapped);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req_item;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp_item;

    code_map_scoreboard code_check;
    int          sent_count = 0;
    int          cycle_count = 0;
    bit          quiet_tail = 1'b0;
    bit          hold_off_req = 1'b0;
    logic [31:0] clock_ms;
    logic [31:0] symbol_pool [POOL_SIZE];

    lru_symbol_to_code_map_core #(
        .TABLE_DEPTH (MAP_DEPTH),
        .MIN_CODE    (FIRST_CODE),
        .MAX_CODE    (LAST_CODE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lru_symbol_to_code_map_core: mismatch");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            code_check.check_code(rsp_item);
    end

    // Stall the result side in random bursts, once for a long stretch
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = LONG_HOLD;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 15);
            rsp_ready <= rst_n && (stall_left == 0);
        end
    end

    function automatic req_item_t make_req(logic op, logic [31:0] sym, logic [31:0] stamp,
                                           logic [7:0] idx, logic pin);
        req_item_t r;
        r.operation   = op;
        r.key_symbol  = sym;
        r.now_ms      = stamp;
        r.slot_index  = idx;
        r.slot_pinned = pin;
        return r;
    endfunction

    // Mostly advancing time, with the odd jump and the stamps at the eviction limit
    function automatic logic [31:0] next_stamp();
        case ($urandom_range(0, 31))
            0:       return TIME_LIMIT;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd0;
            3:       return $urandom();
            default:
            begin
                clock_ms = clock_ms + $urandom_range(0, 40);
                return clock_ms;
            end
        endcase
    endfunction

    function automatic req_item_t random_lookup();
        logic [31:0] sym;
        case ($urandom_range(0, 9))
            0, 1:    sym = $urandom();
            2, 3:    sym = symbol_pool[$urandom_range(0, 7)];
            default: sym = symbol_pool[$urandom_range(0, POOL_SIZE - 1)];
        endcase
        return make_req(OP_LOOKUP, sym, next_stamp(), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
    endfunction

    function automatic req_item_t random_load();
        logic [31:0] sym;
        logic [7:0]  idx;
        sym = ($urandom_range(0, 7) == 0) ? 32'd0 : symbol_pool[$urandom_range(0, POOL_SIZE - 1)];
        idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(FIRST_CODE, END_CODE - 1));
        return make_req(OP_LOAD, sym, next_stamp(), idx, 1'($urandom_range(0, 7) == 0));
    endfunction

    // Offer one transfer and hold it until accepted
    task automatic send_request(req_item_t it);
        req_item  <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        code_check.note_request(it);
        sent_count++;
    endtask

    task automatic issue_request(req_item_t it);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        send_request(it);
    endtask

    task automatic wait_for_codes();
        req_valid <= 1'b0;
        do @(posedge clk); while (code_check.pending() != 0);
    endtask

    // Freeze every scanned slot so a miss finds nothing, then free the table again
    task automatic saturate_table();
        logic [31:0] last_sym;
        logic        pin;
        last_sym = 32'd1;
        for (int i = FIRST_CODE; i < END_CODE; i++)
        begin
            last_sym = $urandom() | 32'd1;
            pin      = 1'($urandom_range(0, 1));
            issue_request(make_req(OP_LOAD, last_sym,
                                   $urandom_range(0, 1) ? TIME_LIMIT : 32'hFFFF_FFFF,
                                   8'(i), pin));
        end
        for (int n = 0; n < 6; n++)
        begin
            if (n % 3 == 2)
                issue_request(make_req(OP_LOOKUP, last_sym, next_stamp(), 8'd0, 1'b0));
            else
                issue_request(make_req(OP_LOOKUP, $urandom(), next_stamp(),
                                       8'($urandom()), 1'b1));
        end
        for (int i = FIRST_CODE; i < END_CODE; i++)
        begin
            clock_ms = clock_ms + $urandom_range(0, 3);
            issue_request(make_req(OP_LOAD,
                                   $urandom_range(0, 1) ? 32'd0
                                       : symbol_pool[$urandom_range(0, POOL_SIZE - 1)],
                                   clock_ms, 8'(i), 1'($urandom_range(0, 15) == 0)));
        end
    endtask

    initial
    begin
        bit hold_done;
        bit freeze_done;
        bit pause_done;
        hold_done   = 1'b0;
        freeze_done = 1'b0;
        pause_done  = 1'b0;
        code_check  = new();
        clock_ms    = $urandom_range(0, 1000);
        symbol_pool[0] = 32'd0;
        symbol_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            symbol_pool[i] = $urandom();

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_item  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // symbol zero hits the first empty slot
        issue_request(make_req(OP_LOOKUP, 32'd0, 32'd5, 8'd0, 1'b0));
        // miss on a fresh table: lowest index wins the tie, stamp at all-ones
        issue_request(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
        // hit with an older time keeps the stamp
        issue_request(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0));
        // slots outside the scan range are never found
        issue_request(make_req(OP_LOAD, 32'hA5A5_A5A5, 32'd7, 8'd255, 1'b1));
        issue_request(make_req(OP_LOOKUP, 32'hA5A5_A5A5, 32'd8, 8'd0, 1'b0));
        issue_request(make_req(OP_LOAD, 32'd0, 32'hFFFF_FFFF, 8'd0, 1'b0));
        // hit on a pinned slot still raises its time
        issue_request(make_req(OP_LOAD, 32'h1234_5678, 32'd1000, 8'd11, 1'b1));
        issue_request(make_req(OP_LOOKUP, 32'h1234_5678, 32'd2000, 8'd0, 1'b0));
        // last code of the range
        issue_request(make_req(OP_LOAD, 32'h8000_0000, TIME_LIMIT, 8'd254, 1'b0));
        issue_request(make_req(OP_LOOKUP, 32'h8000_0000, 32'd3, 8'd0, 1'b0));
        issue_request(make_req(OP_LOAD, 32'd0, 32'd55, 8'd12, 1'b1));
        issue_request(make_req(OP_LOOKUP, 32'd0, 32'd9, 8'd0, 1'b0));
        issue_request(make_req(OP_LOAD, 32'h7FFF_FFFF, 32'd40, 8'd8, 1'b0));
        issue_request(make_req(OP_LOOKUP, 32'd0, 32'd10, 8'd0, 1'b0));
        issue_request(make_req(OP_LOOKUP, 32'h0F0F_0F0F, 32'd11, 8'd0, 1'b0));
        issue_request(make_req(OP_LOOKUP, 32'hF0F0_F0F0, TIME_LIMIT, 8'd0, 1'b0));
        issue_request(make_req(OP_LOAD, 32'h5555_5555, 32'd0, 8'd128, 1'b1));
        issue_request(make_req(OP_LOOKUP, 32'h5555_5555, 32'hFFFF_FFFF, 8'd0, 1'b0));

        // random traffic with the long receiver hold, the frozen table and a drain pause
        while (sent_count < ITEM_TARGET)
        begin
            if (sent_count >= ITEM_TARGET - TAIL_ITEMS)
                quiet_tail = 1'b1;
            if (!hold_done && sent_count >= 300)
            begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!freeze_done && sent_count >= 600)
            begin
                freeze_done = 1'b1;
                saturate_table();
            end
            else if (!pause_done && sent_count >= 1300)
            begin
                pause_done = 1'b1;
                wait_for_codes();
            end
            else if ($urandom_range(0, 4) == 0)
                issue_request(random_load());
            else
                issue_request(random_lookup());
        end

        wait_for_codes();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (code_check.errors == 0 && code_check.pending() == 0)
            $display("lru_symbol_to_code_map_core: match");
        else
            $display("lru_symbol_to_code_map_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/lstcm_pkg.sv
src/lstcm_front.sv
src/lstcm_fifo.sv
src/lstcm_back.sv
src/lru_symbol_to_code_map_core.sv
dv/lru_symbol_to_code_map_core_test.sv
